/* hdl/fwwp_pkg.sv */
`default_nettype none

package fwwp_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ByteW = 8;

	localparam logic [WordW-1:0] ALL_ONES       = '1;
	localparam logic [WordW-1:0] WORD_BYTES     = 32'd4;
	localparam logic [WordW-1:0] APP_BASE_RESET = 32'h0000_4000;
	localparam logic [WordW-1:0] FLASH_END_RESET = 32'h0004_0000;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_PROG   = 2'd2;

	localparam logic REG_APP_BASE  = 1'b0;
	localparam logic REG_FLASH_END = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [WordW-1:0] address;
		logic [WordW-1:0] length;
		logic [ByteW-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [WordW-1:0] word_address;
		logic [WordW-1:0] program_word;
		logic             last;
	} result_t;

	typedef struct packed {
		logic       wr_en;
		logic       index;
		logic [WordW-1:0] data;
	} cfg_wr_t;

endpackage : fwwp_pkg

`default_nettype wire

/* hdl/fwwp_in_stage.sv */
`default_nettype none

module fwwp_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire fwwp_pkg::item_t item,
	input  wire logic            advance,
	output logic                 valid_s1,
	output fwwp_pkg::item_t      item_s1
);
	import fwwp_pkg::*;

	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule : fwwp_in_stage

`default_nettype wire

/* hdl/fwwp_core.sv */
`default_nettype none

module fwwp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fwwp_pkg::cfg_wr_t cfg,
	input  wire logic              valid_s1,
	input  wire fwwp_pkg::item_t   item_s1,
	input  wire logic              slot_free,
	output logic                   advance,
	output logic                   res_valid,
	output fwwp_pkg::result_t      res
);
	import fwwp_pkg::*;

	logic [WordW-1:0] app_base_q, flash_end_q;
	logic             active_q, active_nxt;
	logic [WordW-1:0] next_word_address_q, next_word_address_nxt;
	logic [WordW-1:0] bytes_left_q, bytes_left_nxt;
	logic [WordW-1:0] word_accumulator_q, word_accumulator_nxt;
	logic [1:0]       byte_lane_q, byte_lane_nxt;

	logic [WordW:0]   stop;
	logic             range_ok;
	logic [WordW-1:0] acc_upd;
	logic [WordW-1:0] left_dec;
	logic [1:0]       lane_inc;
	logic             done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_base_q  <= APP_BASE_RESET;
			flash_end_q <= FLASH_END_RESET;
		end else if (cfg.wr_en) begin
			if (cfg.index == REG_APP_BASE) begin
				app_base_q <= cfg.data;
			end else begin
				flash_end_q <= cfg.data;
			end
		end
	end

	assign stop = {1'b0, item_s1.address} + {1'b0, item_s1.length};
	assign range_ok = (item_s1.length != '0)
		&& (item_s1.address >= app_base_q)
		&& (item_s1.address < flash_end_q)
		&& (item_s1.address[1:0] == 2'b00)
		&& !stop[WordW]
		&& (stop[WordW-1:0] <= flash_end_q);

	always_comb begin
		acc_upd = word_accumulator_q;
		unique case (byte_lane_q)
			2'd0: acc_upd[7:0]   = item_s1.data_byte;
			2'd1: acc_upd[15:8]  = item_s1.data_byte;
			2'd2: acc_upd[23:16] = item_s1.data_byte;
			2'd3: acc_upd[31:24] = item_s1.data_byte;
			default: acc_upd = word_accumulator_q;
		endcase
	end

	assign left_dec = bytes_left_q - 32'd1;
	assign lane_inc = byte_lane_q + 2'd1;
	assign done     = (left_dec == '0);

	always_comb begin
		active_nxt            = active_q;
		next_word_address_nxt = next_word_address_q;
		bytes_left_nxt        = bytes_left_q;
		word_accumulator_nxt  = word_accumulator_q;
		byte_lane_nxt         = byte_lane_q;
		res_valid             = 1'b0;
		res                   = '0;
		if (item_s1.operation == OP_BEGIN) begin
			active_nxt           = 1'b0;
			word_accumulator_nxt = ALL_ONES;
			byte_lane_nxt        = 2'd0;
			res_valid            = 1'b1;
			res.kind             = KIND_REJECT;
			if (range_ok) begin
				active_nxt            = 1'b1;
				next_word_address_nxt = item_s1.address;
				bytes_left_nxt        = item_s1.length;
				res.kind              = KIND_ACCEPT;
			end
		end else if (active_q) begin
			word_accumulator_nxt = acc_upd;
			bytes_left_nxt       = left_dec;
			byte_lane_nxt        = lane_inc;
			if (lane_inc == 2'd0 || done) begin
				res_valid             = 1'b1;
				res.kind              = KIND_PROG;
				res.word_address      = next_word_address_q;
				res.program_word      = acc_upd;
				res.last              = done;
				next_word_address_nxt = next_word_address_q + WORD_BYTES;
				word_accumulator_nxt  = ALL_ONES;
				byte_lane_nxt         = 2'd0;
				active_nxt            = !done;
			end
		end
	end

	// an item that yields nothing moves on even with the result slot full
	assign advance = valid_s1 && (slot_free || !res_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q            <= 1'b0;
			next_word_address_q <= '0;
			bytes_left_q        <= '0;
			word_accumulator_q  <= ALL_ONES;
			byte_lane_q         <= 2'd0;
		end else if (advance) begin
			active_q            <= active_nxt;
			next_word_address_q <= next_word_address_nxt;
			bytes_left_q        <= bytes_left_nxt;
			word_accumulator_q  <= word_accumulator_nxt;
			byte_lane_q         <= byte_lane_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (byte_lane_q == 2'd0 && word_accumulator_q == ALL_ONES))
		else $error("idle packer holds a partial word");
	a_active_left: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (bytes_left_q != '0))
		else $error("active write with no bytes left");
	a_active_align: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (next_word_address_q[1:0] == 2'b00))
		else $error("unaligned word address");
	a_prog_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.kind == KIND_PROG) |=> (!active_q || $past(!res.last)))
		else $error("write still active after last program word");
`endif

endmodule : fwwp_core

`default_nettype wire

/* hdl/fwwp_out_stage.sv */
`default_nettype none

module fwwp_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire fwwp_pkg::result_t res,
	output logic                   slot_free,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output fwwp_pkg::result_t      result
);
	import fwwp_pkg::*;

	assign slot_free = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (slot_free) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			result <= res;
		end
	end

endmodule : fwwp_out_stage

`default_nettype wire

/* hdl/flash_write_word_packer_unit.sv */
// A result beat leaves through two registers after its item beat is taken
// (input register, then result register).
// Throughput: one item per cycle unless the output is full; no-result items never wait.
// Reset (arst_n low, asynchronous): no write open, both stages empty,
// app_base = 0x4000 and flash_end = 0x40000.
`default_nettype none

module flash_write_word_packer_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire fwwp_pkg::item_t     item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output fwwp_pkg::result_t        result
);
	import fwwp_pkg::*;

	cfg_wr_t cfg;
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	logic    slot_free;

	assign cfg.wr_en = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	fwwp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	fwwp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.slot_free (slot_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	fwwp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res_valid),
		.res          (res),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule : flash_write_word_packer_unit

`default_nettype wire

/* tb/tb_flash_write_word_packer_unit.sv */
`timescale 1ns / 100ps

module tb_flash_write_word_packer_unit;
	import fwwp_pkg::*;

	localparam int CycleLimit = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = REG_APP_BASE;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	flash_write_word_packer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	item_t       link_items[$];
	result_t     awaited_cmds[$];
	logic [31:0] win_base = APP_BASE_RESET;
	logic [31:0] win_end = FLASH_END_RESET;
	bit          wr_open = 1'b0;
	logic [31:0] wr_addr = '0;
	logic [31:0] wr_left = '0;
	logic [31:0] wr_acc = ALL_ONES;
	logic [1:0]  wr_lane = '0;
	bit          item_beat = 1'b0;
	bit          idle_on = 1'b1;
	int          send_gap = 0;
	int          stall_left = 0;
	int          fail_count = 0;
	int          cycle_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit flash_pack(input item_t it, output result_t cmd);
		logic [32:0] stop;
		cmd = '0;
		if (it.operation == OP_BEGIN) begin
			wr_open = 1'b0;
			wr_acc = ALL_ONES;
			wr_lane = '0;
			stop = {1'b0, it.address} + {1'b0, it.length};
			if (it.length == 0 || it.address < win_base || it.address >= win_end ||
					it.address[1:0] != 2'b00 || stop > {1'b0, win_end}) begin
				cmd.kind = KIND_REJECT;
				return 1'b1;
			end
			wr_open = 1'b1;
			wr_addr = it.address;
			wr_left = it.length;
			cmd.kind = KIND_ACCEPT;
			return 1'b1;
		end
		if (!wr_open)
			return 1'b0;
		wr_acc[{wr_lane, 3'b000} +: 8] = it.data_byte;
		wr_left = wr_left - 1;
		wr_lane = wr_lane + 2'd1;
		if (wr_lane != 2'd0 && wr_left != 0)
			return 1'b0;
		cmd.kind = KIND_PROG;
		cmd.word_address = wr_addr;
		cmd.program_word = wr_acc;
		cmd.last = (wr_left == 0);
		wr_addr = wr_addr + WORD_BYTES;
		wr_acc = ALL_ONES;
		wr_lane = '0;
		if (cmd.last)
			wr_open = 1'b0;
		return 1'b1;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !item_beat)) begin
			if (send_gap > 0) begin
				item_valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (link_items.size() > 0) begin
				item <= link_items.pop_front();
				item_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 17);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				result_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 17);
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		result_t want;
		result_t cmd;
		cycle_count = cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
		item_beat <= item_valid && item_ready;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_cmds.size() == 0) begin
				fail_count = fail_count + 1;
				if (fail_count <= 10)
					$display("unexpected beat at cycle %0d: kind %0d addr %h word %h last %0d",
						cycle_count, result.kind, result.word_address, result.program_word,
						result.last);
			end else begin
				want = awaited_cmds.pop_front();
				if (result.kind !== want.kind || result.word_address !== want.word_address ||
						result.program_word !== want.program_word ||
						result.last !== want.last) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10) begin
						$write("mismatch at cycle %0d: exp kind %0d addr %h word %h last %0d, ",
							cycle_count, want.kind, want.word_address, want.program_word,
							want.last);
						$display("got kind %0d addr %h word %h last %0d",
							result.kind, result.word_address, result.program_word,
							result.last);
					end
				end
			end
		end
		if (arst_n && item_valid && item_ready) begin
			if (flash_pack(item, cmd))
				awaited_cmds.push_back(cmd);
		end
	end

	task automatic add_begin(input logic [31:0] addr, input logic [31:0] len);
		item_t it;
		it.operation = OP_BEGIN;
		it.address = addr;
		it.length = len;
		it.data_byte = $urandom_range(0, 255);
		link_items.push_back(it);
	endtask

	task automatic add_byte(input logic [7:0] b);
		item_t it;
		it.operation = OP_DATA;
		it.address = $urandom;
		it.length = $urandom;
		it.data_byte = b;
		link_items.push_back(it);
	endtask

	task automatic drain();
		@(posedge clk);
		while (link_items.size() != 0 || item_valid || awaited_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input logic [31:0] base, input logic [31:0] fend);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_APP_BASE;
		cfg_data <= base;
		@(negedge clk);
		cfg_index <= REG_FLASH_END;
		cfg_data <= fend;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		win_base = base;
		win_end = fend;
	endtask

	task automatic queue_writes(input int n);
		int made;
		int unsigned len;
		int unsigned slots;
		int unsigned k;
		int unsigned cut;
		longint lo;
		longint room;
		made = 0;
		while (made < n) begin
			lo = (longint'(win_base) + 3) & ~longint'(3);
			room = longint'(win_end) - lo;
			if (room >= 1 && $urandom_range(0, 9) != 0) begin
				len = ($urandom_range(0, 7) == 0) ?
					$urandom_range(1, 40) : $urandom_range(1, 12);
				if (longint'(len) > room)
					len = room;
				slots = (room - len) / 4;
				case ($urandom_range(0, 3))
					0: k = 0;
					1: k = slots;
					default: k = $urandom_range(0, (slots > 1048576) ? 1048576 : slots);
				endcase
				add_begin(lo + 4 * longint'(k), len);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
				for (int i = 0; i < cut; i++)
					add_byte($urandom_range(0, 255));
				made = made + 1 + cut;
			end else begin
				case ($urandom_range(0, 5))
					0: add_byte($urandom_range(0, 255));
					1: add_begin($urandom, $urandom);
					2: add_begin(lo - 4, 4);
					3: add_begin(lo + $urandom_range(1, 3), 1);
					4: add_begin(lo, 0);
					default: add_begin(win_end, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
				endcase
				made = made + 1;
			end
		end
	endtask

	initial begin
		logic [31:0] base;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_begin(32'h0000_4000, 0);
		add_begin(32'h0000_3FFC, 4);
		add_begin(32'h0004_0000, 1);
		add_begin(32'h0000_4001, 3);
		add_begin(32'h0003_FFFC, 8);
		add_begin(32'h0003_FFFC, 4);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'hA5);
		add_byte(8'h5A);
		add_byte(8'h3C);
		add_begin(32'h0000_4000, 6);
		for (int i = 1; i <= 6; i++)
			add_byte(8'h10 * i + i);
		add_begin(32'h0000_4000, 5);
		add_byte(8'hC3);
		add_byte(8'h96);
		add_begin(32'h0000_4100, 1);
		add_byte(8'h81);
		drain();

		set_window(32'h0, 32'hFFFF_FFFF);
		add_begin(32'hFFFF_FFFC, 3);
		add_byte(8'h01);
		add_byte(8'h80);
		add_byte(8'h7F);
		add_begin(32'hFFFF_FFFC, 4);
		add_begin(32'h0, 32'hFFFF_FFFF);
		for (int i = 0; i < 5; i++)
			add_byte($urandom_range(0, 255));
		add_begin(32'hFFFF_FFFF, 1);
		queue_writes(30);
		drain();

		set_window(32'hFFFF_FFFF, 32'h0);
		queue_writes(10);
		drain();

		set_window(32'hFFFF_FFFC, 32'hFFFF_FFFF);
		queue_writes(20);
		drain();

		for (int p = 0; p < 8; p++) begin
			idle_on = (p < 6) && ($urandom_range(0, 3) != 0);
			base = $urandom;
			case ($urandom_range(0, 5))
				0: begin
					base = base & ~32'd3;
					set_window(base, (base > 32'hFFFF_0000) ? 32'hFFFF_FFFF :
						base + $urandom_range(4, 8192));
				end
				1: set_window(32'h0, $urandom_range(4, 8192));
				2: set_window(32'hFFFF_0000 | (base & 32'h0000_FFFC), 32'hFFFF_FFFF);
				3: set_window(base, (base > 32'hFFFF_0000) ? 32'hFFFF_FFFF :
					base + $urandom_range(4, 8192));
				4: set_window(base, $urandom);
				default: set_window(APP_BASE_RESET, FLASH_END_RESET);
			endcase
			queue_writes(70);
			drain();
		end

		repeat (6) @(negedge clk);
		if (fail_count == 0 && awaited_cmds.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
